// ----- hw/rtl/wfrs_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted frame range splitter package
// Shared widths, status codes and controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package wfrs_pkg;

    // Field widths.
    localparam int FRAME_W    = 31;
    localparam int WEIGHT_W   = 32;
    localparam int SUM_W      = 36;
    localparam int SLOT_W     = 4;
    localparam int COUNT_W    = 5;
    localparam int PROD_W     = FRAME_W + WEIGHT_W;
    localparam int RESULT_CAP = 16;
    localparam int S_TDATA_W  = 104;
    localparam int M_TDATA_W  = 72;

    // Result status codes.
    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK          = 2'd0;
    localparam status_t STATUS_BAD_RANGE   = 2'd1;
    localparam status_t STATUS_NO_WORKERS  = 2'd2;
    localparam status_t STATUS_ZERO_WEIGHT = 2'd3;

    // Input operation codes.
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_SPLIT = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_W_RD,
        ST_W_MUL,
        ST_W_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wfrs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wfrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/wfrs_divider.sv -----
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle, with a done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module wfrs_divider #(
    parameter int DIVIDEND_W = 63,
    parameter int DIVISOR_W  = 36
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       busy,
    output logic                       done,
    output logic      [DIVIDEND_W-1:0] quotient,
    output logic      [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    partial;
    logic [DIVISOR_W:0]    diff;

    // One trial subtraction.
    assign partial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = partial - {1'b0, divisor};

    // Control: busy flag, step count and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the quotient in while the remainder builds up.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[DIVISOR_W])
            begin
                rem_reg <= diff[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= partial[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/weighted_frame_range_splitter_core.sv -----
// ----------------------------------------------------------------------------
// Weighted frame range splitter core
// Splits a frame range into one contiguous sub-range per worker, evenly or
// in proportion to weights held in a small table.
// ----------------------------------------------------------------------------
// A store beat writes the table. A bad range or zero worker count goes from check
// straight to emit. A balanced split gives its first beat once the 63-step divider
// is done, then one beat per cycle while the output is not stalled. A weighted split
// sums the weights, then passes each worker but the last through the read, multiply,
// divide and emit states, the last through read and emit. One split is in flight at
// a time; input is taken again once the final beat sits in the output register. Reset
// clears the control state and the table valid bits, so every weight reads as zero.
`default_nettype none

module weighted_frame_range_splitter_core #(
    parameter int MAX_WORKERS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Input beat.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata from bit 0: worker_slot(4), weight_value(32), range_first(31),
    // range_limit(31), worker_count(5), use_weights(1).
    input  wire logic [103:0] s_tdata,
    // tuser: operation(1).
    input  wire logic [0:0]   s_tuser,
    // Result beat.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata from bit 0: part_start(31), part_end(31), worker_index(4), zero pad.
    output logic [71:0]       m_tdata,
    // tuser: status(2).
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    localparam int AW  = $clog2(MAX_WORKERS);
    localparam int CAP = (MAX_WORKERS < wfrs_pkg::RESULT_CAP) ?
                         MAX_WORKERS : wfrs_pkg::RESULT_CAP;
    localparam int FW  = wfrs_pkg::FRAME_W;
    localparam int WW  = wfrs_pkg::WEIGHT_W;
    localparam int SW  = wfrs_pkg::SUM_W;
    localparam int CW  = wfrs_pkg::COUNT_W;
    localparam int PW  = wfrs_pkg::PROD_W;

    // Input fields.
    logic [3:0]    in_slot;
    logic [WW-1:0] in_weight;
    logic [FW-1:0] in_first;
    logic [FW-1:0] in_limit;
    logic [CW-1:0] in_count;
    logic          in_use;
    logic          in_accept;

    assign in_slot   = s_tdata[3:0];
    assign in_weight = s_tdata[35:4];
    assign in_first  = s_tdata[66:36];
    assign in_limit  = s_tdata[97:67];
    assign in_count  = s_tdata[102:98];
    assign in_use    = s_tdata[103];

    wfrs_pkg::state_t  state_reg, state_next;
    wfrs_pkg::status_t err_reg;

    logic [FW-1:0] first_reg, limit_reg, next_start_reg;
    logic [FW-1:0] rem_f_reg, size_reg, base_reg;
    logic [SW-1:0] rem_w_reg;
    logic [WW-1:0] w_reg;
    logic [PW-1:0] prod_reg;
    logic [CW-1:0] req_reg, workers_reg, extra_reg;
    logic [3:0]    idx_reg;
    logic          use_reg;

    logic [MAX_WORKERS-1:0] vld_reg;
    logic                   rd_vld_reg;

    logic          m_tvalid_reg, m_tlast_reg;
    logic [FW-1:0] m_start_reg, m_end_reg;
    logic [3:0]    m_idx_reg;
    logic [1:0]    m_status_reg;

    // Table and divider connections.
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [WW-1:0] ram_rdata, wt_c;
    logic          div_start, div_busy, div_done;
    logic [PW-1:0] div_dividend, div_q;
    logic [SW-1:0] div_divisor, div_r;

    // Split bookkeeping.
    logic [FW-1:0] count_c, size_c, end_c;
    logic [CW-1:0] req_sat_c, workers_c, later_c;
    logic          bad_c, last_worker_c, out_free, out_load;
    logic          round_up_c;
    logic [31:0]   rounded_c, top_c, clamped_c;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == wfrs_pkg::ST_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;

    // A store writes the table directly from the input beat.
    assign ram_we    = in_accept && (s_tuser[0] == wfrs_pkg::OP_STORE)
                       && ({28'd0, in_slot} < 32'(MAX_WORKERS));
    assign ram_waddr = AW'(in_slot);
    assign wt_c      = rd_vld_reg ? ram_rdata : '0;

    // Range checks and active worker count.
    assign count_c   = limit_reg - first_reg;
    assign bad_c     = (limit_reg <= first_reg);
    assign req_sat_c = (req_reg > CW'(CAP)) ? CW'(CAP) : req_reg;
    assign workers_c = (FW'(req_sat_c) <= count_c) ? req_sat_c : count_c[CW-1:0];

    assign later_c       = workers_reg - CW'(idx_reg) - CW'(1);
    assign last_worker_c = ((CW'(idx_reg) + CW'(1)) == workers_reg);

    // Divider operands: balanced split or one weighted share.
    assign div_dividend = use_reg ? prod_reg : PW'(count_c);
    assign div_divisor  = use_reg ? rem_w_reg : SW'(workers_c);

    // Round half up, then clamp to [1, remaining minus later workers].
    assign round_up_c = ({div_r, 1'b0} >= {1'b0, rem_w_reg});
    assign rounded_c  = div_q[31:0] + 32'(round_up_c);
    assign top_c      = 32'(rem_f_reg) - 32'(later_c);
    always_comb
    begin
        clamped_c = rounded_c;
        if (clamped_c == 32'd0)
        begin
            clamped_c = 32'd1;
        end
        if (clamped_c > top_c)
        begin
            clamped_c = top_c;
        end
    end

    // Size of the current worker's sub-range.
    assign size_c = use_reg ? size_reg
                            : base_reg + FW'(CW'(idx_reg) < extra_reg);
    assign end_c  = next_start_reg + size_c;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wfrs_pkg::ST_IDLE:
            begin
                if (in_accept && (s_tuser[0] == wfrs_pkg::OP_SPLIT))
                begin
                    state_next = wfrs_pkg::ST_CHECK;
                end
            end
            wfrs_pkg::ST_CHECK:
            begin
                if (bad_c || (req_reg == '0))
                begin
                    state_next = wfrs_pkg::ST_EMIT;
                end
                else if (use_reg)
                begin
                    state_next = wfrs_pkg::ST_SUM_RD;
                end
                else
                begin
                    state_next = wfrs_pkg::ST_DIV_WAIT;
                end
            end
            wfrs_pkg::ST_SUM_RD:
            begin
                state_next = wfrs_pkg::ST_SUM_ACC;
            end
            wfrs_pkg::ST_SUM_ACC:
            begin
                if (wt_c == '0)
                begin
                    state_next = wfrs_pkg::ST_EMIT;
                end
                else if (last_worker_c)
                begin
                    state_next = wfrs_pkg::ST_W_RD;
                end
                else
                begin
                    state_next = wfrs_pkg::ST_SUM_RD;
                end
            end
            wfrs_pkg::ST_W_RD:
            begin
                state_next = last_worker_c ? wfrs_pkg::ST_EMIT : wfrs_pkg::ST_W_MUL;
            end
            wfrs_pkg::ST_W_MUL:
            begin
                state_next = wfrs_pkg::ST_W_DIV_GO;
            end
            wfrs_pkg::ST_W_DIV_GO:
            begin
                state_next = wfrs_pkg::ST_DIV_WAIT;
            end
            wfrs_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = wfrs_pkg::ST_EMIT;
                end
            end
            wfrs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    if ((err_reg != wfrs_pkg::STATUS_OK) || last_worker_c)
                    begin
                        state_next = wfrs_pkg::ST_IDLE;
                    end
                    else if (use_reg)
                    begin
                        state_next = wfrs_pkg::ST_W_RD;
                    end
                end
            end
            default:
            begin
                state_next = wfrs_pkg::ST_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = AW'(idx_reg);
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            wfrs_pkg::ST_CHECK:
            begin
                div_start = !bad_c && (req_reg != '0) && !use_reg;
            end
            wfrs_pkg::ST_SUM_RD:
            begin
                ram_re = 1'b1;
            end
            wfrs_pkg::ST_W_RD:
            begin
                ram_re = !last_worker_c;
            end
            wfrs_pkg::ST_W_DIV_GO:
            begin
                div_start = 1'b1;
            end
            wfrs_pkg::ST_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= wfrs_pkg::ST_IDLE;
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                vld_reg[ram_waddr] <= 1'b1;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Split datapath.
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            rd_vld_reg <= vld_reg[ram_raddr];
        end
        case (state_reg)
            wfrs_pkg::ST_IDLE:
            begin
                first_reg <= in_first;
                limit_reg <= in_limit;
                req_reg   <= in_count;
                use_reg   <= in_use;
            end
            wfrs_pkg::ST_CHECK:
            begin
                workers_reg    <= workers_c;
                idx_reg        <= '0;
                rem_w_reg      <= '0;
                rem_f_reg      <= count_c;
                next_start_reg <= first_reg;
                if (bad_c)
                begin
                    err_reg <= wfrs_pkg::STATUS_BAD_RANGE;
                end
                else if (req_reg == '0)
                begin
                    err_reg <= wfrs_pkg::STATUS_NO_WORKERS;
                end
                else
                begin
                    err_reg <= wfrs_pkg::STATUS_OK;
                end
            end
            wfrs_pkg::ST_SUM_ACC:
            begin
                // Accumulate the weight sum; a zero weight aborts the split.
                rem_w_reg <= rem_w_reg + SW'(wt_c);
                if (wt_c == '0)
                begin
                    err_reg <= wfrs_pkg::STATUS_ZERO_WEIGHT;
                end
                else if (last_worker_c)
                begin
                    idx_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 4'd1;
                end
            end
            wfrs_pkg::ST_W_RD:
            begin
                size_reg <= rem_f_reg;
            end
            wfrs_pkg::ST_W_MUL:
            begin
                w_reg    <= wt_c;
                prod_reg <= PW'(rem_f_reg) * PW'(wt_c);
            end
            wfrs_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (use_reg)
                    begin
                        size_reg  <= clamped_c[FW-1:0];
                        rem_f_reg <= rem_f_reg - clamped_c[FW-1:0];
                        rem_w_reg <= rem_w_reg - SW'(w_reg);
                    end
                    else
                    begin
                        base_reg  <= div_q[FW-1:0];
                        extra_reg <= div_r[CW-1:0];
                    end
                end
            end
            wfrs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    next_start_reg <= end_c;
                    idx_reg        <= idx_reg + 4'd1;
                end
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (err_reg != wfrs_pkg::STATUS_OK)
            begin
                m_start_reg <= '0;
                m_end_reg   <= '0;
                m_idx_reg   <= '0;
                m_tlast_reg <= 1'b1;
            end
            else
            begin
                m_start_reg <= next_start_reg;
                m_end_reg   <= end_c;
                m_idx_reg   <= idx_reg;
                m_tlast_reg <= last_worker_c;
            end
            m_status_reg <= err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_idx_reg, m_end_reg, m_start_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_tlast_reg;

    // Weight table.
    wfrs_ram #(
        .WIDTH(WW),
        .DEPTH(MAX_WORKERS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(in_weight),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Shared divider for balanced and weighted shares.
    wfrs_divider #(
        .DIVIDEND_W(PW),
        .DIVISOR_W (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q),
        .remainder(div_r)
    );

    // The divider is never restarted while it is still working.
    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
        else $error("divider started while busy");

    // A finished division is only seen while the controller waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == wfrs_pkg::ST_DIV_WAIT))
        else $error("division finished outside the wait state");

    // Every worker that gets a sub-range gets at least one frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (err_reg == wfrs_pkg::STATUS_OK)) |-> (size_c != '0))
        else $error("empty sub-range issued");

    // An error beat closes the split and carries no range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (err_reg != wfrs_pkg::STATUS_OK)) |=>
        (m_tlast && (m_tdata == '0)))
        else $error("malformed error beat");

endmodule

`default_nettype wire

// ----- dv/weighted_frame_range_splitter_core_tb.sv -----
// ----------------------------------------------------------------------------
// Weighted frame range splitter core testbench
// Drives weight stores and range splits over the input stream, predicts the
// sub-ranges of each split and checks every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module weighted_frame_range_splitter_core_tb;

    localparam int NUM_WORKERS = 16;
    localparam int EXP_DEPTH = 256;
    localparam longint CYCLE_LIMIT = 3000000;

    // One predicted result beat.
    typedef struct {
        logic [30:0]       part_start;
        logic [30:0]       part_end;
        logic [3:0]        worker_index;
        wfrs_pkg::status_t status;
        logic              last;
    } part_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    // Predictor state and the ring of expected beats.
    logic [31:0] weight_shadow [NUM_WORKERS];
    part_t       exp_ring [EXP_DEPTH];
    int          exp_wr;
    int          exp_rd;

    int     error_count;
    int     beats_sent;
    int     beats_checked;
    longint cycle_count;
    bit     hold_off;
    bit     no_gaps;

    weighted_frame_range_splitter_core #(
        .MAX_WORKERS (NUM_WORKERS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock generation.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Expected beats not yet checked.
    function automatic int pending_count();
        return exp_wr - exp_rd;
    endfunction

    // Append one expected beat.
    function automatic void add_expected(part_t p);
        exp_ring[exp_wr % EXP_DEPTH] = p;
        exp_wr++;
    endfunction

    // Cycle counter and run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d results pending", $time, pending_count());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Random gap length: mostly short, a few long.
    function automatic int gap_len();
        if (no_gaps)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    // Work out the result beats of one input item.
    function automatic void predict_parts(logic op, logic [3:0] slot, logic [31:0] wval,
                                          logic [30:0] first, logic [30:0] limit,
                                          logic [4:0] req, logic weighted);
        int unsigned workers;
        int unsigned count;
        int unsigned later;
        logic [35:0] wsum;
        logic [30:0] frames_left;
        logic [30:0] cursor;
        logic [63:0] prod;
        logic [63:0] whole;
        logic [63:0] frac;
        logic [63:0] half;
        logic [63:0] rounded;
        logic [63:0] top;
        logic [30:0] sizes [NUM_WORKERS];
        part_t p;
        p = '{default: '0};
        if (op == wfrs_pkg::OP_STORE)
        begin
            weight_shadow[slot] = wval;
            return;
        end
        p.last = 1'b1;
        if (limit <= first)
        begin
            p.status = wfrs_pkg::STATUS_BAD_RANGE;
            add_expected(p);
            return;
        end
        if (req == 0)
        begin
            p.status = wfrs_pkg::STATUS_NO_WORKERS;
            add_expected(p);
            return;
        end
        if (req > NUM_WORKERS)
            req = 5'(NUM_WORKERS);
        count = limit - first;
        workers = (req < count) ? req : count;
        if (weighted)
        begin
            wsum = '0;
            for (int i = 0; i < workers; i++)
            begin
                if (weight_shadow[i] == 0)
                begin
                    p.status = wfrs_pkg::STATUS_ZERO_WEIGHT;
                    add_expected(p);
                    return;
                end
                wsum = wsum + weight_shadow[i];
            end
            frames_left = 31'(count);
            for (int i = 0; i < workers; i++)
            begin
                later = workers - i - 1;
                if (later == 0)
                begin
                    sizes[i] = frames_left;
                    break;
                end
                prod = 64'(frames_left) * 64'(weight_shadow[i]);
                whole = prod / wsum;
                frac = prod % wsum;
                half = wsum / 2 + wsum % 2;
                rounded = whole + ((frac >= half) ? 1 : 0);
                top = 64'(frames_left) - later;
                if (rounded < 1)
                    rounded = 1;
                if (rounded > top)
                    rounded = top;
                sizes[i] = rounded[30:0];
                frames_left = frames_left - rounded[30:0];
                wsum = wsum - weight_shadow[i];
            end
        end
        else
        begin
            for (int i = 0; i < workers; i++)
                sizes[i] = 31'(count / workers + ((i < count % workers) ? 1 : 0));
        end
        cursor = first;
        for (int i = 0; i < workers; i++)
        begin
            p.part_start = cursor;
            p.part_end = cursor + sizes[i];
            p.worker_index = 4'(i);
            p.status = wfrs_pkg::STATUS_OK;
            p.last = (i + 1 == workers);
            add_expected(p);
            cursor = p.part_end;
        end
    endfunction

    // Send one input beat and record what it should produce.
    task automatic send_item(logic op, logic [3:0] slot, logic [31:0] wval,
                             logic [30:0] first, logic [30:0] limit,
                             logic [4:0] req, logic weighted);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {weighted, req, limit, first, wval, slot};
        predict_parts(op, slot, wval, first, limit, req, weighted);
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
    endtask

    task automatic store_weight(logic [3:0] slot, logic [31:0] wval);
        send_item(wfrs_pkg::OP_STORE, slot, wval, 31'($urandom), 31'($urandom),
                  5'($urandom), 1'($urandom));
    endtask

    task automatic split_range(logic [30:0] first, logic [30:0] limit,
                               logic [4:0] req, logic weighted);
        send_item(wfrs_pkg::OP_SPLIT, 4'($urandom), $urandom, first, limit, req, weighted);
    endtask

    // Wait until every predicted beat has been checked.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_count() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Result sink with random stalls.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                @(posedge clk);
                m_tready <= 1'b0;
                repeat (2500) @(posedge clk);
                hold_off = 1'b0;
            end
            stall = gap_len();
            if (stall > 0)
            begin
                @(posedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
            end
            @(posedge clk);
            m_tready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        part_t exp_p;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_checked++;
            if (pending_count() == 0)
            begin
                $display("%0t unexpected result beat %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                exp_p = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_tdata[30:0] !== exp_p.part_start || m_tdata[61:31] !== exp_p.part_end
                    || m_tdata[65:62] !== exp_p.worker_index || m_tdata[71:66] !== '0
                    || m_tuser !== exp_p.status || m_tlast !== exp_p.last)
                begin
                    $display("%0t mismatch: expected start %0d end %0d worker %0d status %0d last %0d",
                             $time, exp_p.part_start, exp_p.part_end, exp_p.worker_index,
                             exp_p.status, exp_p.last);
                    $display("%0t          actual   start %0d end %0d worker %0d status %0d last %0d",
                             $time, m_tdata[30:0], m_tdata[61:31], m_tdata[65:62],
                             m_tuser, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Errors, extremes and both modes with hand-picked values.
    task automatic test_directed();
        split_range(31'd5, 31'd5, 5'd4, 1'b0);
        split_range(31'h7FFFFFFF, 31'd0, 5'd0, 1'b1);
        split_range(31'd0, 31'd10, 5'd0, 1'b0);
        split_range(31'd0, 31'd10, 5'd3, 1'b1);
        split_range(31'd0, 31'h7FFFFFFF, 5'd16, 1'b0);
        split_range(31'd0, 31'd3, 5'd31, 1'b0);
        split_range(31'd100, 31'd117, 5'd5, 1'b0);
        for (int i = 0; i < NUM_WORKERS; i++)
            store_weight(4'(i), 32'(i + 1));
        store_weight(4'd15, 32'hFFFFFFFF);
        store_weight(4'd0, 32'hFFFFFFFF);
        split_range(31'd0, 31'h7FFFFFFF, 5'd16, 1'b1);
        split_range(31'd7, 31'd9, 5'd16, 1'b1);
        split_range(31'h7FFFFFF0, 31'h7FFFFFFF, 5'd20, 1'b1);
        split_range(31'd0, 31'd1000, 5'd1, 1'b1);
        store_weight(4'd2, 32'd0);
        split_range(31'd0, 31'd1000, 5'd2, 1'b1);
        split_range(31'd0, 31'd1000, 5'd3, 1'b1);
        store_weight(4'd2, 32'd1);
        drain();
    endtask

    // Random stores and splits, mostly with valid ranges and weights.
    task automatic test_random(int n);
        logic [30:0] first;
        logic [30:0] span;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                store_weight(4'($urandom), ($urandom_range(0, 15) == 0) ? 32'd0 :
                             ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 1000));
            end
            else
            begin
                first = 31'($urandom);
                case ($urandom_range(0, 3))
                    0: span = 31'($urandom_range(0, 20));
                    1: span = 31'($urandom_range(0, 5000));
                    default: span = 31'($urandom);
                endcase
                if ($urandom_range(0, 15) == 0)
                    split_range(first, 31'($urandom), 5'($urandom), 1'($urandom));
                else
                    split_range(first, (32'(first) + span > 32'h7FFFFFFF) ? 31'h7FFFFFFF :
                                first + span, 5'($urandom_range(0, 20)), 1'($urandom));
            end
        end
        drain();
    endtask

    // Long receiver hold-off while the sender keeps offering splits.
    task automatic test_backpressure();
        hold_off = 1'b1;
        no_gaps = 1'b1;
        for (int k = 0; k < 12; k++)
            split_range(31'($urandom_range(0, 1000)), 31'($urandom_range(2000, 9000)),
                        5'd16, 1'b0);
        no_gaps = 1'b0;
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        exp_wr = 0;
        exp_rd = 0;
        error_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        cycle_count = 0;
        hold_off = 1'b0;
        no_gaps = 1'b0;
        for (int i = 0; i < NUM_WORKERS; i++)
            weight_shadow[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(330);
        $display("Sent %0d input beats (stores and splits), checked %0d result beats,",
                 beats_sent, beats_checked);
        $display("covering error splits, balanced and weighted splits and output stalls.");
        if (error_count == 0 && pending_count() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/wfrs_pkg.sv
hw/rtl/wfrs_ram.sv
hw/rtl/wfrs_divider.sv
hw/rtl/weighted_frame_range_splitter_core.sv
dv/weighted_frame_range_splitter_core_tb.sv
